[src/ght_pkg.sv]
`default_nettype none
package ght_pkg;

   localparam int SLOTS           = 16;
   localparam int PARAMS_PER_SLOT = 32;
   localparam int MAX_TARGETS     = 16;
   localparam int MATERIAL_SLOTS  = 16;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PARAM_W = (PARAMS_PER_SLOT > 1) ? $clog2(PARAMS_PER_SLOT) : 1;
   localparam int KIND_W  = 3;
   localparam int ROW_W   = PARAMS_PER_SLOT * KIND_W;

   // request codes
   localparam logic [1:0] REQ_CREATE  = 2'd0;
   localparam logic [1:0] REQ_DESTROY = 2'd1;
   localparam logic [1:0] REQ_RELOAD  = 2'd2;
   localparam logic [1:0] REQ_UPDATE  = 2'd3;

   // status codes
   localparam logic [3:0] ST_OK               = 4'd0;
   localparam logic [3:0] ST_NO_RUNTIME       = 4'd1;
   localparam logic [3:0] ST_CREATE_REJECTED  = 4'd2;
   localparam logic [3:0] ST_LIMIT            = 4'd3;
   localparam logic [3:0] ST_HANDLE_INVALID   = 4'd4;
   localparam logic [3:0] ST_STALE            = 4'd5;
   localparam logic [3:0] ST_RELOAD_INVALID   = 4'd6;
   localparam logic [3:0] ST_RELOAD_REJECTED  = 4'd7;
   localparam logic [3:0] ST_TARGET_LIMIT     = 4'd8;
   localparam logic [3:0] ST_MATERIAL_SLOT    = 4'd9;
   localparam logic [3:0] ST_DESTROY_REJECTED = 4'd10;
   localparam logic [3:0] ST_PAYLOAD_INVALID  = 4'd11;
   localparam logic [3:0] ST_ARTEFACT_STALE   = 4'd12;
   localparam logic [3:0] ST_UNSUPPORTED      = 4'd13;
   localparam logic [3:0] ST_TYPE_MISMATCH    = 4'd14;
   localparam logic [3:0] ST_UPDATE_REJECTED  = 4'd15;

   // value kinds
   localparam logic [7:0] KIND_NONE = 8'd0;
   localparam logic [7:0] KIND_BYTE = 8'd1;
   localparam logic [7:0] KIND_W8A  = 8'd2;
   localparam logic [7:0] KIND_W8B  = 8'd3;
   localparam logic [7:0] KIND_W16  = 8'd4;
   localparam logic [7:0] KIND_TEXT = 8'd5;

   localparam int DESTROY_LEN  = 8;
   localparam int RELOAD_MIN   = 8;
   localparam int RELOAD_HEAD  = 20;
   localparam int TARGET_BYTES = 20;
   localparam int UPDATE_HEAD  = 21;
   localparam int TEXT_PREFIX  = 4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] handle;
      logic [63:0] artefact;
      logic [15:0] payload_length;
      logic [11:0] target_count;
      logic [31:0] highest_material_slot;
      logic [31:0] parameter_id;
      logic [7:0]  value_kind;
      logic [31:0] text_length_prefix;
      logic        runtime_accept;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] new_handle;
      logic [63:0] bound_artefact;
      logic [11:0] bound_targets;
      logic [5:0]  updated_parameter;
      logic [2:0]  updated_kind;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

[src/ght_req_if.sv]
`default_nettype none
interface ght_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] handle;
   logic [63:0] artefact;
   logic [15:0] payload_length;
   logic [11:0] target_count;
   logic [31:0] highest_material_slot;
   logic [31:0] parameter_id;
   logic [7:0]  value_kind;
   logic [31:0] text_length_prefix;
   logic        runtime_accept;

   modport source (
      output valid, req_type, handle, artefact, payload_length, target_count,
             highest_material_slot, parameter_id, value_kind, text_length_prefix,
             runtime_accept,
      input  ready
   );
   modport sink (
      input  valid, req_type, handle, artefact, payload_length, target_count,
             highest_material_slot, parameter_id, value_kind, text_length_prefix,
             runtime_accept,
      output ready
   );
endinterface
`default_nettype wire

[src/ght_rsp_if.sv]
`default_nettype none
interface ght_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [63:0] new_handle;
   logic [63:0] bound_artefact;
   logic [11:0] bound_targets;
   logic [5:0]  updated_parameter;
   logic [2:0]  updated_kind;

   modport source (
      output valid, status, new_handle, bound_artefact, bound_targets,
             updated_parameter, updated_kind,
      input  ready
   );
   modport sink (
      input  valid, status, new_handle, bound_artefact, bound_targets,
             updated_parameter, updated_kind,
      output ready
   );
endinterface
`default_nettype wire

[src/ght_ram.sv]
`default_nettype none
module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

[src/ght_ctrl.sv]
`default_nettype none
module ght_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ght_pkg::dp_status_type status_in,
   output ght_pkg::ctrl_cmd_type      cmd
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the output register can take the result
            if (status_in.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[src/ght_dp.sv]
`default_nettype none
module ght_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ght_pkg::ctrl_cmd_type cmd,
   output ght_pkg::dp_status_type     status_out,
   input  wire ght_pkg::req_item_type req_item,
   input  wire logic                  csr_we,
   input  wire logic                  csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ght_pkg::rsp_item_type      rsp_item
);

   localparam int SW = ght_pkg::SLOT_W;
   localparam int PW = ght_pkg::PARAM_W;
   localparam int KW = ght_pkg::KIND_W;
   localparam int RW = ght_pkg::ROW_W;

   logic                        rp_ff;
   logic [ght_pkg::SLOTS-1:0]   live_ff, live_in;
   logic [ght_pkg::SLOTS-1:0]   rowv_ff, rowv_in;
   logic [31:0]                 gen_ff [ght_pkg::SLOTS];
   logic [31:0]                 gen_in [ght_pkg::SLOTS];
   logic [63:0]                 art_ff [ght_pkg::SLOTS];
   logic [63:0]                 art_in [ght_pkg::SLOTS];

   ght_pkg::req_item_type       q_ff;
   logic [SW-1:0]               slot_ff, slot_sel;
   logic                        idx_ok_ff, idx_ok_sel;
   logic                        found;
   logic [SW-1:0]               free_slot;
   logic [31:0]                 low_word;

   ght_pkg::rsp_item_type       rsp_ff, rsp_in;
   logic                        rsp_valid_ff;

   logic                        ram_we;
   logic [RW-1:0]               ram_wdata, ram_rdata, row;
   logic [31:0]                 cur_gen, gen_first, gen_next;
   logic [63:0]                 cur_art;
   logic                        cur_live, hchk, rp_fail;
   logic [PW-1:0]               pidx;
   logic [KW-1:0]               est, kind3;
   logic [16:0]                 reload_len;
   logic [15:0]                 vsize;
   logic                        size_ok, param_ok;

   // first free slot, lowest wins
   always_comb begin
      found     = 1'b0;
      free_slot = '0;
      for (int i = ght_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            found     = 1'b1;
            free_slot = SW'(i);
         end
      end
   end

   assign low_word = req_item.handle[31:0];

   always_comb begin
      if (req_item.req_type == ght_pkg::REQ_CREATE) begin
         slot_sel   = free_slot;
         idx_ok_sel = found;
      end else begin
         slot_sel   = SW'(low_word - 32'd1);
         idx_ok_sel = (low_word != 32'd0) && (low_word <= 32'(ght_pkg::SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_ff      <= req_item;
         slot_ff   <= slot_sel;
         idx_ok_ff <= idx_ok_sel;
      end
   end

   ght_ram #(.WIDTH(RW), .DEPTH(ght_pkg::SLOTS)) u_rows (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (ram_wdata),
      .re    (cmd.capture),
      .raddr (slot_sel),
      .rdata (ram_rdata)
   );

   assign cur_gen   = gen_ff[slot_ff];
   assign cur_art   = art_ff[slot_ff];
   assign cur_live  = live_ff[slot_ff];
   assign hchk      = idx_ok_ff && cur_live && (cur_gen == q_ff.handle[63:32]);
   assign rp_fail   = rp_ff && !q_ff.runtime_accept;
   assign gen_first = (cur_gen == 32'd0) ? 32'd1 : cur_gen;
   assign gen_next  = (cur_gen == 32'hFFFF_FFFF) ? 32'd1 : cur_gen + 32'd1;

   // a row never written since its slot was last freed reads as all zero
   assign row   = rowv_ff[slot_ff] ? ram_rdata : '0;
   assign pidx  = PW'(q_ff.parameter_id - 32'd1);
   assign est   = row[pidx*KW +: KW];
   assign kind3 = q_ff.value_kind[KW-1:0];

   assign reload_len = 17'(ght_pkg::RELOAD_HEAD)
                     + 17'(ght_pkg::TARGET_BYTES) * {5'd0, q_ff.target_count};
   assign vsize      = q_ff.payload_length - 16'(ght_pkg::UPDATE_HEAD);

   assign param_ok = (q_ff.parameter_id != 32'd0)
                  && (q_ff.parameter_id <= 32'(ght_pkg::PARAMS_PER_SLOT))
                  && (q_ff.value_kind != ght_pkg::KIND_NONE)
                  && (q_ff.value_kind <= ght_pkg::KIND_TEXT);

   always_comb begin
      case (q_ff.value_kind)
         ght_pkg::KIND_BYTE: size_ok = (vsize == 16'd1);
         ght_pkg::KIND_W8A,
         ght_pkg::KIND_W8B:  size_ok = (vsize == 16'd8);
         ght_pkg::KIND_W16:  size_ok = (vsize == 16'd16);
         ght_pkg::KIND_TEXT: size_ok = (vsize >= 16'(ght_pkg::TEXT_PREFIX))
               && (q_ff.text_length_prefix
                   == 32'(vsize) - 32'(ght_pkg::TEXT_PREFIX));
         default:            size_ok = 1'b0;
      endcase
   end

   always_comb begin
      live_in   = live_ff;
      rowv_in   = rowv_ff;
      gen_in    = gen_ff;
      art_in    = art_ff;
      ram_we    = 1'b0;
      ram_wdata = row;
      ram_wdata[pidx*KW +: KW] = kind3;
      rsp_in    = '0;
      if (cmd.commit) begin
         unique case (q_ff.req_type)
            ght_pkg::REQ_CREATE: begin
               if (!rp_ff) begin
                  rsp_in.status = ght_pkg::ST_NO_RUNTIME;
               end else if (!idx_ok_ff) begin
                  rsp_in.status = ght_pkg::ST_LIMIT;
               end else begin
                  // the generation bump of a fresh slot stays even on reject
                  gen_in[slot_ff] = gen_first;
                  if (!q_ff.runtime_accept) begin
                     rsp_in.status = ght_pkg::ST_CREATE_REJECTED;
                  end else begin
                     live_in[slot_ff]  = 1'b1;
                     rsp_in.status     = ght_pkg::ST_OK;
                     rsp_in.new_handle = {gen_first, 32'(slot_ff) + 32'd1};
                  end
               end
            end
            ght_pkg::REQ_DESTROY: begin
               if (q_ff.payload_length != 16'(ght_pkg::DESTROY_LEN)) begin
                  rsp_in.status = ght_pkg::ST_HANDLE_INVALID;
               end else if (!hchk) begin
                  rsp_in.status = ght_pkg::ST_OK;
               end else if (rp_fail) begin
                  rsp_in.status = ght_pkg::ST_DESTROY_REJECTED;
               end else begin
                  live_in[slot_ff] = 1'b0;
                  rowv_in[slot_ff] = 1'b0;
                  art_in[slot_ff]  = '0;
                  gen_in[slot_ff]  = gen_next;
                  rsp_in.status    = ght_pkg::ST_OK;
               end
            end
            ght_pkg::REQ_RELOAD: begin
               if (q_ff.payload_length < 16'(ght_pkg::RELOAD_MIN)) begin
                  rsp_in.status = ght_pkg::ST_HANDLE_INVALID;
               end else if (!hchk) begin
                  rsp_in.status = ght_pkg::ST_STALE;
               end else if (q_ff.payload_length < 16'(ght_pkg::RELOAD_HEAD)) begin
                  rsp_in.status = ght_pkg::ST_RELOAD_INVALID;
               end else if ((q_ff.artefact == 64'd0) || (q_ff.target_count == 12'd0)
                     || ({1'b0, q_ff.payload_length} != reload_len)) begin
                  rsp_in.status = ght_pkg::ST_RELOAD_REJECTED;
               end else if (q_ff.target_count > 12'(ght_pkg::MAX_TARGETS)) begin
                  rsp_in.status = ght_pkg::ST_TARGET_LIMIT;
               end else if (q_ff.highest_material_slot
                     >= 32'(ght_pkg::MATERIAL_SLOTS)) begin
                  rsp_in.status = ght_pkg::ST_MATERIAL_SLOT;
               end else if (rp_fail) begin
                  rsp_in.status = ght_pkg::ST_RELOAD_REJECTED;
               end else begin
                  art_in[slot_ff]       = q_ff.artefact;
                  rsp_in.status         = ght_pkg::ST_OK;
                  rsp_in.bound_artefact = q_ff.artefact;
                  rsp_in.bound_targets  = q_ff.target_count;
               end
            end
            ght_pkg::REQ_UPDATE: begin
               if (q_ff.payload_length < 16'(ght_pkg::UPDATE_HEAD)) begin
                  rsp_in.status = ght_pkg::ST_PAYLOAD_INVALID;
               end else if (!hchk) begin
                  rsp_in.status = ght_pkg::ST_STALE;
               end else if (q_ff.artefact != cur_art) begin
                  rsp_in.status = ght_pkg::ST_ARTEFACT_STALE;
               end else if (!param_ok) begin
                  rsp_in.status = ght_pkg::ST_UNSUPPORTED;
               end else if (!size_ok) begin
                  rsp_in.status = ght_pkg::ST_PAYLOAD_INVALID;
               end else if ((est != '0) && (est != kind3)) begin
                  rsp_in.status = ght_pkg::ST_TYPE_MISMATCH;
               end else if (rp_fail) begin
                  rsp_in.status = ght_pkg::ST_UPDATE_REJECTED;
               end else begin
                  ram_we           = 1'b1;
                  rowv_in[slot_ff] = 1'b1;
                  rsp_in.status    = ght_pkg::ST_OK;
                  rsp_in.updated_parameter = q_ff.parameter_id[5:0];
                  rsp_in.updated_kind      = kind3;
               end
            end
            default: rsp_in.status = ght_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff   <= 1'b1;
         live_ff <= '0;
         rowv_ff <= '0;
         for (int i = 0; i < ght_pkg::SLOTS; i++) begin
            gen_ff[i] <= '0;
            art_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            rp_ff <= csr_wdata;
         end
         live_ff <= live_in;
         rowv_ff <= rowv_in;
         gen_ff  <= gen_in;
         art_ff  <= art_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status_out.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item            = rsp_ff;

endmodule
`default_nettype wire

[src/generational_handle_table.sv]
// Generational handle table of 16 slots serving create, destroy, reload and parameter
// update requests, one status transaction per request. The accept cycle registers a
// request and reads the slot's parameter-kind row from a 16-row memory; the execute
// state then checks the handle and commits the slot update once the output register is
// free. The result sits in an output register, and the next request is taken while it
// waits; if it is still held when the next request finishes, that request waits in its
// commit cycle. Parameter rows carry a valid bit per slot, so there is no clearing pass
// after reset. The user writes runtime_present on the csr_ channel only while the block
// is idle; the block itself does not enforce this. csr_ready is always high.
`default_nettype none
module generational_handle_table (
   input  wire logic   clock,
   input  wire logic   reset,
   ght_req_if.sink     req_chan,
   ght_rsp_if.source   rsp_chan,
   input  wire logic   csr_valid,
   output logic        csr_ready,
   input  wire logic   csr_wdata
);

   ght_pkg::ctrl_cmd_type  cmd;
   ght_pkg::dp_status_type dp_status;
   ght_pkg::req_item_type  req_item;
   ght_pkg::rsp_item_type  rsp_item;

   assign csr_ready = 1'b1;

   assign req_item.req_type              = req_chan.req_type;
   assign req_item.handle                = req_chan.handle;
   assign req_item.artefact              = req_chan.artefact;
   assign req_item.payload_length        = req_chan.payload_length;
   assign req_item.target_count          = req_chan.target_count;
   assign req_item.highest_material_slot = req_chan.highest_material_slot;
   assign req_item.parameter_id          = req_chan.parameter_id;
   assign req_item.value_kind            = req_chan.value_kind;
   assign req_item.text_length_prefix    = req_chan.text_length_prefix;
   assign req_item.runtime_accept        = req_chan.runtime_accept;

   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status_in (dp_status),
      .cmd       (cmd)
   );

   ght_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status_out (dp_status),
      .req_item   (req_item),
      .csr_we     (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_chan.status            = rsp_item.status;
   assign rsp_chan.new_handle        = rsp_item.new_handle;
   assign rsp_chan.bound_artefact    = rsp_item.bound_artefact;
   assign rsp_chan.bound_targets     = rsp_item.bound_targets;
   assign rsp_chan.updated_parameter = rsp_item.updated_parameter;
   assign rsp_chan.updated_kind      = rsp_item.updated_kind;

endmodule
`default_nettype wire
